FILE: rtl/pcus_pkg.sv
`default_nettype none

package pcus_pkg;

    // Field widths of one update beat
    localparam int unsigned COORD_W = 8;
    localparam int unsigned KEY_W   = 64;
    localparam int unsigned HGT_W   = 16;
    localparam int unsigned TS_W    = 63;

    // Field widths of one result beat
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned SLOT_W   = 8;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_WRITTEN = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/pcus_if.sv
`default_nettype none

// Update channel: one column update per beat
interface pcus_req_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [pcus_pkg::COORD_W-1:0]  local_x;
    logic signed [pcus_pkg::COORD_W-1:0]  local_z;
    logic        [pcus_pkg::KEY_W-1:0]    block_key;
    logic signed [pcus_pkg::HGT_W-1:0]    height;
    logic        [pcus_pkg::TS_W-1:0]     timestamp_ms;

    modport source (
        output valid, local_x, local_z, block_key, height, timestamp_ms,
        input  ready
    );
    modport sink (
        input  valid, local_x, local_z, block_key, height, timestamp_ms,
        output ready
    );
endinterface

// Result channel: one status beat per update
interface pcus_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [pcus_pkg::STATUS_W-1:0]    status;
    logic [pcus_pkg::SLOT_W-1:0]      palette_slot;
    logic                             new_entry;

    modport source (
        output valid, status, palette_slot, new_entry,
        input  ready
    );
    modport sink (
        input  valid, status, palette_slot, new_entry,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/palette_column_update_store.sv
`default_nettype none
// Palette column update store.
//
// i_req carries one column update per beat (local x/z, block key, height,
// timestamp); o_rsp returns one result beat per update: status, palette
// slot and a new-entry flag. Both use valid/ready; a beat moves on a clock
// edge where both are high.
//
// The palette is a chain of PALETTE_DEPTH cells. The query key is held
// while the hit flag and index ripple one cell per cycle; a column inside
// the chunk walks the whole chain before its result is registered, while
// an update outside the chunk skips the walk. Items are processed one at
// a time; the next beat is accepted as soon as the search of the previous
// one has finished, even while its result still waits.
//
// After reset the column store is swept to zero with i_req.ready low.
// The palette starts empty.
// If o_rsp.ready stays low, the result register holds and the next search
// waits at its end until the register is free.
module palette_column_update_store #(
    parameter int unsigned CHUNK_SIZE    = 16,
    parameter int unsigned PALETTE_DEPTH = 256
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    pcus_req_if.sink    i_req,
    pcus_rsp_if.source  o_rsp
);

    localparam int unsigned COLS   = CHUNK_SIZE * CHUNK_SIZE;
    localparam int unsigned ADDR_W = $clog2(COLS);
    localparam int unsigned IDX_W  = $clog2(PALETTE_DEPTH);
    localparam int unsigned CNT_W  = $clog2(PALETTE_DEPTH + 1);
    localparam int unsigned WORD_W = pcus_pkg::SLOT_W + pcus_pkg::HGT_W;

    typedef enum logic [2:0] {
        S_CLEAR  = 3'b001,
        S_IDLE   = 3'b010,
        S_SEARCH = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [ADDR_W-1:0]              r_clr_addr;
    logic [CNT_W-1:0]               r_cnt;
    logic [CNT_W-1:0]               r_count;
    logic                           r_skip;
    logic [ADDR_W-1:0]              r_col;
    logic [pcus_pkg::KEY_W-1:0]     r_key;
    logic [pcus_pkg::HGT_W-1:0]     r_height;
    logic [pcus_pkg::TS_W-1:0]      r_last_ms;

    logic                           r_out_valid;
    logic [pcus_pkg::STATUS_W-1:0]  r_out_status;
    logic [pcus_pkg::SLOT_W-1:0]    r_out_slot;
    logic                           r_out_new;

    logic [WORD_W-1:0]              r_col_mem [COLS];

    logic                           accept;
    logic                           in_range;
    logic [ADDR_W-1:0]              in_col;
    logic                           out_free;
    logic                           finish;
    logic                           append;
    logic                           col_we;
    logic [ADDR_W-1:0]              col_addr;
    logic [WORD_W-1:0]              col_data;
    logic [pcus_pkg::STATUS_W-1:0]  fin_status;
    logic [pcus_pkg::SLOT_W-1:0]    fin_slot;
    logic [IDX_W+pcus_pkg::SLOT_W-1:0] hit_ext;
    logic [CNT_W+pcus_pkg::SLOT_W-1:0] cnt_ext;

    logic                           chain_hit [PALETTE_DEPTH+1];
    logic [IDX_W-1:0]               chain_idx [PALETTE_DEPTH+1];

    // Input side
    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign in_range    = !i_req.local_x[pcus_pkg::COORD_W-1]
                      && !i_req.local_z[pcus_pkg::COORD_W-1]
                      && ($unsigned(i_req.local_x) < pcus_pkg::COORD_W'(CHUNK_SIZE))
                      && ($unsigned(i_req.local_z) < pcus_pkg::COORD_W'(CHUNK_SIZE));
    assign in_col      = ADDR_W'(32'($unsigned(i_req.local_z)) * CHUNK_SIZE
                               + 32'($unsigned(i_req.local_x)));

    // Palette chain
    assign chain_hit[0] = 1'b0;
    assign chain_idx[0] = '0;

    for (genvar g = 0; g < PALETTE_DEPTH; g++) begin : g_cell
        pcus_cell #(
            .INDEX (g),
            .IDX_W (IDX_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_wr_en   (append),
            .i_wr_idx  (r_count[IDX_W-1:0]),
            .i_wr_key  (r_key),
            .i_qry_key (r_key),
            .i_count   (r_count),
            .i_hit     (chain_hit[g]),
            .i_idx     (chain_idx[g]),
            .o_hit     (chain_hit[g+1]),
            .o_idx     (chain_idx[g+1])
        );
    end

    // Search end: decide the outcome once the chain has settled
    assign out_free = !r_out_valid || o_rsp.ready;
    assign finish   = (r_state == S_SEARCH) && (r_cnt == CNT_W'(PALETTE_DEPTH)) && out_free;
    assign hit_ext  = {{pcus_pkg::SLOT_W{1'b0}}, chain_idx[PALETTE_DEPTH]};
    assign cnt_ext  = {{pcus_pkg::SLOT_W{1'b0}}, r_count};

    always_comb begin
        append     = 1'b0;
        fin_status = pcus_pkg::STATUS_WRITTEN;
        fin_slot   = '0;
        if (r_skip) begin
            fin_status = pcus_pkg::STATUS_IGNORED;
        end else if (chain_hit[PALETTE_DEPTH]) begin
            fin_slot = hit_ext[pcus_pkg::SLOT_W-1:0];
        end else if (r_count < CNT_W'(PALETTE_DEPTH)) begin
            fin_slot = cnt_ext[pcus_pkg::SLOT_W-1:0];
            append   = finish;
        end else begin
            fin_status = pcus_pkg::STATUS_FULL;
        end
    end

    // Column store write port: clearing sweep or update
    always_comb begin
        if (r_state == S_CLEAR) begin
            col_we   = 1'b1;
            col_addr = r_clr_addr;
            col_data = '0;
        end else begin
            col_we   = finish && (fin_status == pcus_pkg::STATUS_WRITTEN);
            col_addr = r_col;
            col_data = {fin_slot, r_height};
        end
    end

    always_ff @(posedge i_clk) begin
        if (col_we) begin
            r_col_mem[col_addr] <= col_data;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == ADDR_W'(COLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (finish) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_cnt       <= '0;
            r_count     <= '0;
            r_last_ms   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (accept) begin
                r_cnt     <= in_range ? '0 : CNT_W'(PALETTE_DEPTH);
                r_last_ms <= i_req.timestamp_ms;
            end else if ((r_state == S_SEARCH) && (r_cnt != CNT_W'(PALETTE_DEPTH))) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (append) begin
                r_count <= r_count + 1'b1;
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the accepted beat
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_skip   <= !in_range;
            r_col    <= in_col;
            r_key    <= i_req.block_key;
            r_height <= i_req.height;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_status <= fin_status;
            r_out_slot   <= fin_slot;
            r_out_new    <= append;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.palette_slot = r_out_slot;
    assign o_rsp.new_entry    = r_out_new;

endmodule

`default_nettype wire

FILE: rtl/pcus_cell.sv
`default_nettype none

// One palette entry: holds a key, compares it with the query and passes
// the running hit flag and index on to the next cell every cycle.
module pcus_cell #(
    parameter int unsigned INDEX = 0,
    parameter int unsigned IDX_W = 8,
    parameter int unsigned CNT_W = 9
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_wr_en,
    input  wire logic [IDX_W-1:0]           i_wr_idx,
    input  wire logic [pcus_pkg::KEY_W-1:0] i_wr_key,
    input  wire logic [pcus_pkg::KEY_W-1:0] i_qry_key,
    input  wire logic [CNT_W-1:0]           i_count,
    input  wire logic                       i_hit,
    input  wire logic [IDX_W-1:0]           i_idx,
    output logic                            o_hit,
    output logic [IDX_W-1:0]                o_idx
);

    logic [pcus_pkg::KEY_W-1:0] r_key;
    logic                       r_hit;
    logic [IDX_W-1:0]           r_idx;
    logic                       n_hit;
    logic [IDX_W-1:0]           n_idx;
    logic                       live;

    // Only entries below the fill count take part in the compare
    assign live  = (i_count > CNT_W'(INDEX));
    assign n_hit = i_hit | (live && (r_key == i_qry_key));
    assign n_idx = i_hit ? i_idx : IDX_W'(INDEX);

    // Load the key on append
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_idx == IDX_W'(INDEX))) begin
            r_key <= i_wr_key;
        end
    end

    // Advance the hit token
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
    end

    assign o_hit = r_hit;
    assign o_idx = r_idx;

endmodule

`default_nettype wire

FILE: rtl/pcus_checker.sv
`default_nettype none

module pcus_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_rsp_valid,
    input wire logic                          i_rsp_ready,
    input wire logic [pcus_pkg::STATUS_W-1:0] i_rsp_status,
    input wire logic [pcus_pkg::SLOT_W-1:0]   i_rsp_slot,
    input wire logic                          i_rsp_new
);

    // No result comes out of reset
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_rsp_valid)
        else $error("result valid right after reset");

    // Only the three defined status codes appear
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_status == pcus_pkg::STATUS_WRITTEN
                      || i_rsp_status == pcus_pkg::STATUS_IGNORED
                      || i_rsp_status == pcus_pkg::STATUS_FULL))
        else $error("undefined status code");

    // An update that was not written reports slot zero and no new entry
    a_unwritten_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_status != pcus_pkg::STATUS_WRITTEN)
            |-> (i_rsp_slot == '0 && !i_rsp_new))
        else $error("unwritten update carries slot or new flag");

    // A stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_status)
            && $stable(i_rsp_slot) && $stable(i_rsp_new)))
        else $error("stalled result beat changed");

endmodule

bind palette_column_update_store pcus_checker u_pcus_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.status),
    .i_rsp_slot   (o_rsp.palette_slot),
    .i_rsp_new    (o_rsp.new_entry)
);

`default_nettype wire
